// ----- src/subpixel_cell_compositor_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the subpixel cell compositor.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef SUBPIXEL_CELL_COMPOSITOR_MACROS_SVH
`define SUBPIXEL_CELL_COMPOSITOR_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge outside reset.
`define SCC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("scc assertion failed");

// Consequent must hold in the cycle in which the antecedent holds.
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scc assertion failed");

`else

`define SCC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define SCC_ASSERT_IMP(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/scc_pkg.sv -----
// ---------------------------------------------------------------------------
// scc_pkg
// Types, register codes and helper functions shared by the subpixel cell
// compositor modules.
// ---------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

    // Field and store widths.
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W       = 36;
    localparam int VALUE_W     = 16;
    localparam int PIXEL_X_W   = 10;
    localparam int COL_W       = 13;
    localparam int OUT_WIDTH_W = 11;
    localparam int CELL_W      = 3;
    localparam int MAP_W       = 32;
    localparam int NUM_WEIGHTS = 4;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_WIDTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_COLS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_ROWS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELL_MAP  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_0  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_1  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_2  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHT_3  = 3'd7;

    // Register reset values.
    localparam logic [OUT_WIDTH_W-1:0] RST_OUT_WIDTH = 11'd1024;
    localparam logic [CELL_W-1:0]      RST_CELL_COLS = 3'd3;
    localparam logic [CELL_W-1:0]      RST_CELL_ROWS = 3'd1;
    localparam logic [MAP_W-1:0]       RST_CELL_MAP  = 32'd36;
    localparam logic [WEIGHT_W-1:0]    RST_WEIGHT    = 16'd32768;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                frame_start;
    } t_in_data;

    typedef struct packed {
        logic [VALUE_W-1:0]   value_0;
        logic [VALUE_W-1:0]   value_1;
        logic [VALUE_W-1:0]   value_2;
        logic [VALUE_W-1:0]   value_3;
        logic [PIXEL_X_W-1:0] pixel_x;
        logic                 row_end;
    } t_out_data;

    typedef struct packed {
        logic [OUT_WIDTH_W-1:0]               out_width;
        logic [CELL_W-1:0]                    cell_cols;
        logic [CELL_W-1:0]                    cell_rows;
        logic [MAP_W-1:0]                     cell_map;
        logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight;
    } t_cfg;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [1:0]          chan;
        logic                chan_ok;
        logic [COL_W-1:0]    col;
        logic                first;
        logic                clear;
        logic                last_col;
        logic                emit;
        logic                row_end;
    } t_item;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [LEVEL_W-1:0] level;
    } t_queue_status;

    // Cell sizes of zero act as one and sizes above four act as four.
    function automatic logic [CELL_W-1:0] clamp_cell(input logic [CELL_W-1:0] v);
        logic [CELL_W-1:0] r;
        if (v == 3'd0) begin
            r = 3'd1;
        end else if (v > 3'd4) begin
            r = 3'd4;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/subpixel_cell_compositor.sv -----
// ---------------------------------------------------------------------------
// subpixel_cell_compositor: weighted binning of sample cells into pixels.
// A pixel passes through the queue, the load stage, the finished pixel stage and the output register.
// Throughput: one sample per cycle while the output is not stalled.
// Reset clears counters, queue, valid bits and registers; no store sweep.
// ---------------------------------------------------------------------------
`default_nettype none

`include "subpixel_cell_compositor_macros.svh"

module subpixel_cell_compositor #(
    parameter int MAX_WIDTH = 1024,
    parameter int CHANNELS  = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  scc_pkg::t_in_data            i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output scc_pkg::t_out_data           o_out_data,
    input  wire                          i_out_stall,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [scc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [scc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import scc_pkg::*;

    t_cfg          r_cfg;
    logic          q_push;
    logic          q_pop;
    t_item         q_in_item;
    t_item         q_head;
    t_queue_status q_status;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.out_width <= RST_OUT_WIDTH;
            r_cfg.cell_cols <= RST_CELL_COLS;
            r_cfg.cell_rows <= RST_CELL_ROWS;
            r_cfg.cell_map  <= RST_CELL_MAP;
            r_cfg.weight    <= {NUM_WEIGHTS{RST_WEIGHT}};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OUT_WIDTH: r_cfg.out_width <= i_cfg_data[OUT_WIDTH_W-1:0];
                CFG_CELL_COLS: r_cfg.cell_cols <= i_cfg_data[CELL_W-1:0];
                CFG_CELL_ROWS: r_cfg.cell_rows <= i_cfg_data[CELL_W-1:0];
                CFG_CELL_MAP:  r_cfg.cell_map  <= i_cfg_data[MAP_W-1:0];
                CFG_WEIGHT_0:  r_cfg.weight[0] <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_1:  r_cfg.weight[1] <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_2:  r_cfg.weight[2] <= i_cfg_data[WEIGHT_W-1:0];
                CFG_WEIGHT_3:  r_cfg.weight[3] <= i_cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: position tracking and classification.
    scc_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .CHANNELS  (CHANNELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_push     (q_push),
        .o_item     (q_in_item),
        .i_q_status (q_status)
    );

    // Queue between the two halves.
    scc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (q_in_item),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // Back end: accumulation, line store and output register.
    scc_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .CHANNELS  (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (q_head),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // The front never pushes into a full queue and the back never pops an
    // empty one; the fill level moves by at most one entry per cycle.
    `SCC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, q_push, !q_status.full)
    `SCC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, q_status.empty, !q_pop)
    `SCC_ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n, q_status.level <= LEVEL_W'(QUEUE_DEPTH))
    `SCC_ASSERT_IMP(a_level_step, i_clk, i_rst_n, q_status.level != $past(q_status.level), (q_status.level == $past(q_status.level) + 3'd1) || (q_status.level == $past(q_status.level) - 3'd1))

endmodule

`default_nettype wire

// ----- src/scc_front.sv -----
// ---------------------------------------------------------------------------
// scc_front
// Accepts samples, tracks the position inside the cell and the output row,
// and classifies each sample by channel and block boundary.
// ---------------------------------------------------------------------------
`default_nettype none

module scc_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int CHANNELS  = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  scc_pkg::t_cfg          i_cfg,
    input  wire                    i_in_valid,
    input  scc_pkg::t_in_data      i_in_data,
    output logic                   o_in_stall,
    output logic                   o_push,
    output scc_pkg::t_item         o_item,
    input  scc_pkg::t_queue_status i_q_status
);
    import scc_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = ((AW + 1) > OUT_WIDTH_W) ? (AW + 1) : OUT_WIDTH_W;

    logic [1:0]    r_col_in, n_col_in;
    logic [1:0]    r_row_in, n_row_in;
    logic [AW-1:0] r_out_col, n_out_col;

    logic              accept;
    logic [1:0]        col0, row0;
    logic [AW-1:0]     x0;
    logic [CELL_W-1:0] cols, rows;
    logic [4:0]        cell_sum;
    logic [3:0]        cell_idx;
    logic [1:0]        chan;
    logic [WW-1:0]     eff_w, ow, x_inc;
    logic              last_col, last_row, last_x;

    // The queue being full holds off the source.
    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;
    assign o_push     = accept;

    // Position of this sample; a frame start restarts all counters.
    always_comb begin
        col0 = i_in_data.frame_start ? 2'd0 : r_col_in;
        row0 = i_in_data.frame_start ? 2'd0 : r_row_in;
        x0   = i_in_data.frame_start ? '0 : r_out_col;
    end

    // Effective bounds from the registers.
    always_comb begin
        cols = clamp_cell(i_cfg.cell_cols);
        rows = clamp_cell(i_cfg.cell_rows);
        ow   = WW'(i_cfg.out_width);
        if (ow == '0) begin
            eff_w = WW'(1);
        end else if (ow > WW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = ow;
        end
    end

    // Channel lookup in the cell map and block boundary flags.
    always_comb begin
        cell_sum = (5'(row0) * 5'(cols)) + 5'(col0);
        cell_idx = cell_sum[3:0];
        chan     = i_cfg.cell_map[{cell_idx, 1'b0} +: 2];
        x_inc    = WW'(x0) + WW'(1);
        last_col = (3'(col0) + 3'd1) >= cols;
        last_row = (3'(row0) + 3'd1) >= rows;
        last_x   = x_inc >= eff_w;
    end

    // Queue entry for the back end.
    always_comb begin
        o_item.sample   = i_in_data.sample;
        o_item.chan     = chan;
        o_item.chan_ok  = int'(chan) < CHANNELS;
        o_item.col      = COL_W'(x0);
        o_item.first    = (col0 == 2'd0);
        o_item.clear    = (col0 == 2'd0) && (row0 == 2'd0);
        o_item.last_col = last_col;
        o_item.emit     = last_col && last_row;
        o_item.row_end  = last_x;
    end

    // Counter advance for the next sample.
    always_comb begin
        n_col_in  = col0;
        n_row_in  = row0;
        n_out_col = x0;
        if (last_col) begin
            n_col_in = 2'd0;
            if (last_x) begin
                n_out_col = '0;
                n_row_in  = last_row ? 2'd0 : row0 + 2'd1;
            end else begin
                n_out_col = AW'(x_inc);
            end
        end else begin
            n_col_in = col0 + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_in  <= 2'd0;
            r_row_in  <= 2'd0;
            r_out_col <= '0;
        end else if (accept) begin
            r_col_in  <= n_col_in;
            r_row_in  <= n_row_in;
            r_out_col <= n_out_col;
        end
    end

endmodule

`default_nettype wire

// ----- src/scc_queue.sv -----
// ---------------------------------------------------------------------------
// scc_queue
// Short first-in first-out queue of classified samples between the front
// and the back, so that each side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module scc_queue (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  scc_pkg::t_item         i_item,
    input  wire                    i_pop,
    output scc_pkg::t_item         o_head,
    output scc_pkg::t_queue_status o_status
);
    import scc_pkg::*;

    t_item              r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [LEVEL_W-1:0] r_level, n_level;

    assign o_head          = r_entry[r_rd_ptr];
    assign o_status.full   = (r_level == LEVEL_W'(QUEUE_DEPTH));
    assign o_status.empty  = (r_level == '0);
    assign o_status.level  = r_level;

    // Fill level follows pushes and pops.
    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + LEVEL_W'(1);
        end else if (i_pop && !i_push) begin
            n_level = r_level - LEVEL_W'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

// ----- src/scc_back.sv -----
// ---------------------------------------------------------------------------
// scc_back
// Multiply-accumulate pipeline: weights each sample, keeps the running sums
// of the current column, moves them through the line store between cell
// rows and rounds the finished pixel into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module scc_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int CHANNELS  = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  scc_pkg::t_cfg          i_cfg,
    input  scc_pkg::t_item         i_head,
    input  scc_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output scc_pkg::t_out_data     o_out_data,
    input  wire                    i_out_stall
);
    import scc_pkg::*;

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int LINE_W = CHANNELS * ACC_W;

    // Rounds at bit 15 and saturates to the output width.
    function automatic logic [VALUE_W-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] t;
        logic [VALUE_W-1:0] r;
        t = {1'b0, acc} + (ACC_W + 1)'(16384);
        if (t[ACC_W:15] > (ACC_W - 14)'(65535)) begin
            r = '1;
        end else begin
            r = t[30:15];
        end
        return r;
    endfunction

    logic              advance;
    logic [PROD_W-1:0] prod;

    // Line store of partial sums, one row of all channels per column.
    logic [LINE_W-1:0] r_line_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd_data;

    // Accumulate stage.
    logic              r_s2_valid;
    t_item             r_s2_item;
    logic [PROD_W-1:0] r_prod;
    logic              r_fwd;
    logic [ACC_W-1:0]  r_run [CHANNELS];
    logic [ACC_W-1:0]  n_run [CHANNELS];
    logic [LINE_W-1:0] n_line;

    // Finished pixel stage.
    logic                 r_s3_valid;
    logic [ACC_W-1:0]     r_s3_sum [CHANNELS];
    logic [PIXEL_X_W-1:0] r_s3_px;
    logic                 r_s3_row_end;

    // Output register.
    logic               r_out_valid;
    t_out_data          r_out_data;
    logic [VALUE_W-1:0] value [NUM_WEIGHTS];

    // The whole pipeline holds while a result waits at the output.
    assign advance = !(r_out_valid && i_out_stall);
    assign o_pop   = advance && !i_q_status.empty;
    assign prod    = PROD_W'(i_head.sample) * PROD_W'(i_cfg.weight[i_head.chan]);

    // Load stage: weight the sample and fetch the column from the line store.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s2_item <= i_head;
            r_prod    <= prod;
            r_fwd     <= r_s2_valid && r_s2_item.last_col && (r_s2_item.col == i_head.col);
            if (o_pop && i_head.first && !i_head.clear) begin
                r_rd_data <= r_line_mem[i_head.col[AW-1:0]];
            end
        end
    end

    // Running sums: cleared at a block start, taken from the line store at a
    // new cell row, or from the column just written back when it is the same.
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            logic [ACC_W-1:0] base;
            logic [ACC_W-1:0] add;
            if (r_s2_item.first && r_s2_item.clear) begin
                base = '0;
            end else if (r_s2_item.first && !r_fwd) begin
                base = r_rd_data[k*ACC_W +: ACC_W];
            end else begin
                base = r_run[k];
            end
            if (r_s2_item.chan_ok && (r_s2_item.chan == 2'(k))) begin
                add = ACC_W'(r_prod);
            end else begin
                add = '0;
            end
            n_run[k] = base + add;
            n_line[k*ACC_W +: ACC_W] = n_run[k];
        end
    end

    // Running sums and write-back at the last sample of a cell row.
    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid) begin
            r_run <= n_run;
            if (r_s2_item.last_col) begin
                r_line_mem[r_s2_item.col[AW-1:0]] <= n_line;
            end
        end
    end

    // Finished pixel payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s3_sum     <= n_run;
            r_s3_px      <= r_s2_item.col[PIXEL_X_W-1:0];
            r_s3_row_end <= r_s2_item.row_end;
        end
    end

    // Rounding per channel; channels that are not built read zero.
    for (genvar g = 0; g < NUM_WEIGHTS; g++) begin : g_value
        if (g < CHANNELS) begin : g_built
            assign value[g] = round_sat(r_s3_sum[g]);
        end else begin : g_absent
            assign value[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data.value_0 <= value[0];
            r_out_data.value_1 <= value[1];
            r_out_data.value_2 <= value[2];
            r_out_data.value_3 <= value[3];
            r_out_data.pixel_x <= r_s3_px;
            r_out_data.row_end <= r_s3_row_end;
        end
    end

    // Valid bits of the pipeline stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s2_valid  <= o_pop;
            r_s3_valid  <= r_s2_valid && r_s2_item.emit;
            r_out_valid <= r_s3_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
